/* hdl/cau_pkg.sv */
// Package with the shared constants and codes of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;
endpackage
`default_nettype wire

/* hdl/cau_if.sv */
// Valid/ready channel interfaces for operand and result transactions.
`default_nettype none
interface cau_in_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;
  modport source(output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink(input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic [1:0]                   status;
  modport source(output valid, res_re, res_im, status, input ready);
  modport sink(input valid, res_re, res_im, status, output ready);
endinterface
`default_nettype wire

/* hdl/cau_div_pipe.sv */
// Pipelined restoring divider for the real and imaginary quotient parts.
`default_nettype none
module cau_div_pipe #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [2*DATA_WIDTH-1:0]   num_re,
  input  wire logic [2*DATA_WIDTH-1:0]   num_im,
  input  wire logic [2*DATA_WIDTH-1:0]   den,
  output logic [DATA_WIDTH-1:0]          q_re,
  output logic [DATA_WIDTH-1:0]          q_im,
  output logic [2*DATA_WIDTH-1:0]        rem_re,
  output logic [2*DATA_WIDTH-1:0]        rem_im,
  output logic [2*DATA_WIDTH-1:0]        den_out,
  output logic                           ovf_re,
  output logic                           ovf_im
);
  localparam int W  = DATA_WIDTH;
  localparam int DW = 2 * DATA_WIDTH;
  localparam int RW = 3 * DATA_WIDTH + FRAC_BITS;

  logic [RW-1:0] rem_r [0:W][0:1];
  logic [W-1:0]  q_r   [0:W][0:1];
  logic          ovf_r [0:W][0:1];
  logic [DW-1:0] den_r [0:W];

  logic [RW-1:0] x_nxt [0:1];

  always_comb begin
    x_nxt[0] = RW'(num_re) << FRAC_BITS;
    x_nxt[1] = RW'(num_im) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      for (int p = 0; p < 2; p++) begin
        rem_r[0][p] <= x_nxt[p];
        q_r[0][p]   <= '0;
        ovf_r[0][p] <= x_nxt[p] >= (RW'(den) << W);
      end
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    logic [RW-1:0] dsh;
    assign dsh = RW'(den_r[s-1]) << (W - s);
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_r[s-1];
        for (int p = 0; p < 2; p++) begin
          ovf_r[s][p] <= ovf_r[s-1][p];
          if (rem_r[s-1][p] >= dsh) begin
            rem_r[s][p] <= rem_r[s-1][p] - dsh;
            q_r[s][p]   <= q_r[s-1][p] | (W'(1) << (W - s));
          end else begin
            rem_r[s][p] <= rem_r[s-1][p];
            q_r[s][p]   <= q_r[s-1][p];
          end
        end
      end
    end
  end

  assign q_re    = q_r[W][0];
  assign q_im    = q_r[W][1];
  assign rem_re  = rem_r[W][0][DW-1:0];
  assign rem_im  = rem_r[W][1][DW-1:0];
  assign den_out = den_r[W];
  assign ovf_re  = ovf_r[W][0];
  assign ovf_im  = ovf_r[W][1];
endmodule
`default_nettype wire

/* hdl/complex_arithmetic_unit.sv */
// Top level of the pipelined complex add, subtract, multiply and divide unit.
// The unit accepts one transaction per cycle while the result side is not stalled,
// and each result passes one stage of multipliers, one stage of sums,
// a divider prepare stage, DATA_WIDTH restoring divider stages that each
// settle one quotient bit, and a rounding and saturation output stage.
// All operations pass through the same stages, so results come back in order, and a
// stall on the result side holds the whole pipeline without loss.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  cau_in_if.sink   in_ch,
  cau_out_if.source out_ch
);
  localparam int W  = DATA_WIDTH;
  localparam int DW = 2 * DATA_WIDTH;
  localparam int SW = 2 * DATA_WIDTH + 1;
  localparam int MW = 2 * DATA_WIDTH + 1;
  localparam logic [MW-1:0] TOP  = MW'(1) << (W - 1);
  localparam logic [MW-1:0] HALF = MW'(1) << (FRAC_BITS - 1);

  logic adv;
  logic out_valid_r;
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic                 v1_r;
  logic [1:0]           f1_r;
  logic signed [W-1:0]  a_r, b_r, c_r, d_r;
  logic signed [DW-1:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r, p_cc_r, p_dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r   <= in_ch.func;
      a_r    <= in_ch.a_re;
      b_r    <= in_ch.a_im;
      c_r    <= in_ch.b_re;
      d_r    <= in_ch.b_im;
      p_ac_r <= in_ch.a_re * in_ch.b_re;
      p_bd_r <= in_ch.a_im * in_ch.b_im;
      p_ad_r <= in_ch.a_re * in_ch.b_im;
      p_bc_r <= in_ch.a_im * in_ch.b_re;
      p_cc_r <= in_ch.b_re * in_ch.b_re;
      p_dd_r <= in_ch.b_im * in_ch.b_im;
    end
  end

  logic                 v2_r;
  logic [1:0]           f2_r;
  logic signed [SW-1:0] s_re_r, s_im_r;
  logic [DW-1:0]        den_r;
  logic signed [SW-1:0] s_re_nxt, s_im_nxt;

  always_comb begin
    case (f1_r)
      cau_pkg::FN_ADD: begin
        s_re_nxt = SW'(a_r) + SW'(c_r);
        s_im_nxt = SW'(b_r) + SW'(d_r);
      end
      cau_pkg::FN_SUB: begin
        s_re_nxt = SW'(a_r) - SW'(c_r);
        s_im_nxt = SW'(b_r) - SW'(d_r);
      end
      cau_pkg::FN_MUL: begin
        s_re_nxt = SW'(p_ac_r) - SW'(p_bd_r);
        s_im_nxt = SW'(p_ad_r) + SW'(p_bc_r);
      end
      default: begin
        s_re_nxt = SW'(p_ac_r) + SW'(p_bd_r);
        s_im_nxt = SW'(p_bc_r) - SW'(p_ad_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_r   <= f1_r;
      s_re_r <= s_re_nxt;
      s_im_r <= s_im_nxt;
      den_r  <= DW'(p_cc_r) + DW'(p_dd_r);
    end
  end

  logic [1:0]    neg3;
  logic [DW-1:0] mag3 [0:1];
  logic [MW-1:0] dm3  [0:1];
  logic [SW-1:0] abs_re, abs_im;

  always_comb begin
    neg3[0] = s_re_r[SW-1];
    neg3[1] = s_im_r[SW-1];
    abs_re  = neg3[0] ? -s_re_r : s_re_r;
    abs_im  = neg3[1] ? -s_im_r : s_im_r;
    mag3[0] = abs_re[DW-1:0];
    mag3[1] = abs_im[DW-1:0];
    for (int p = 0; p < 2; p++) begin
      if (f2_r == cau_pkg::FN_MUL) begin
        dm3[p] = (MW'(mag3[p]) + HALF) >> FRAC_BITS;
      end else begin
        dm3[p] = MW'(mag3[p]);
      end
    end
  end

  logic          sv_r [0:W];
  logic [1:0]    sf_r [0:W];
  logic          sz_r [0:W];
  logic [1:0]    sn_r [0:W];
  logic [MW-1:0] sm_r [0:W][0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= W; s++) begin
        sv_r[s] <= 1'b0;
      end
    end else if (adv) begin
      sv_r[0] <= v2_r;
      for (int s = 1; s <= W; s++) begin
        sv_r[s] <= sv_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf_r[0]    <= f2_r;
      sz_r[0]    <= den_r == '0;
      sn_r[0]    <= neg3;
      sm_r[0][0] <= dm3[0];
      sm_r[0][1] <= dm3[1];
      for (int s = 1; s <= W; s++) begin
        sf_r[s]    <= sf_r[s-1];
        sz_r[s]    <= sz_r[s-1];
        sn_r[s]    <= sn_r[s-1];
        sm_r[s][0] <= sm_r[s-1][0];
        sm_r[s][1] <= sm_r[s-1][1];
      end
    end
  end

  logic [W-1:0]  q_re, q_im;
  logic [DW-1:0] rem_re, rem_im, den_q;
  logic          ovf_re, ovf_im;

  cau_div_pipe #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .en     (adv),
    .num_re (mag3[0]),
    .num_im (mag3[1]),
    .den    (den_r),
    .q_re   (q_re),
    .q_im   (q_im),
    .rem_re (rem_re),
    .rem_im (rem_im),
    .den_out(den_q),
    .ovf_re (ovf_re),
    .ovf_im (ovf_im)
  );

  logic [MW-1:0] m_fin [0:1];
  logic [W-1:0]  r_fin [0:1];
  logic [1:0]    sat_p;
  logic [W-1:0]  qv    [0:1];
  logic [DW-1:0] rv    [0:1];
  logic [1:0]    ov;
  logic [1:0]    status_nxt;

  always_comb begin
    qv[0] = q_re;
    qv[1] = q_im;
    rv[0] = rem_re;
    rv[1] = rem_im;
    ov    = {ovf_im, ovf_re};
    for (int p = 0; p < 2; p++) begin
      if (sf_r[W] == cau_pkg::FN_DIV) begin
        if (ov[p]) begin
          m_fin[p] = TOP + MW'(1);
        end else begin
          m_fin[p] = MW'(qv[p]) + MW'(rv[p] >= (den_q - rv[p]));
        end
      end else begin
        m_fin[p] = sm_r[W][p];
      end
      sat_p[p] = 1'b0;
      if (sn_r[W][p]) begin
        if (m_fin[p] > TOP) begin
          sat_p[p] = 1'b1;
          r_fin[p] = W'(-TOP);
        end else begin
          r_fin[p] = W'(-m_fin[p]);
        end
      end else begin
        if (m_fin[p] > TOP - MW'(1)) begin
          sat_p[p] = 1'b1;
          r_fin[p] = W'(TOP - MW'(1));
        end else begin
          r_fin[p] = W'(m_fin[p]);
        end
      end
    end
    if (sf_r[W] == cau_pkg::FN_DIV && sz_r[W]) begin
      status_nxt = cau_pkg::ST_DZ;
      r_fin[0]   = '0;
      r_fin[1]   = '0;
    end else if (sat_p != 2'b00) begin
      status_nxt = cau_pkg::ST_SAT;
    end else begin
      status_nxt = cau_pkg::ST_OK;
    end
  end

  logic [W-1:0] res_re_r, res_im_r;
  logic [1:0]   status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re_r <= r_fin[0];
      res_im_r <= r_fin[1];
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.res_re = res_re_r;
  assign out_ch.res_im = res_im_r;
  assign out_ch.status = status_r;
endmodule
`default_nettype wire

/* hdl/cau_checker.sv */
// Port-level assertions for the complex arithmetic unit and their bind.
`default_nettype none
module cau_checker #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_WIDTH-1:0] res_re,
  input wire logic [DATA_WIDTH-1:0] res_im,
  input wire logic [1:0]            status
);
  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im)
      && $stable(status))
    else $error("Stalled result transaction changed.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3)
    else $error("Undefined status code.");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == cau_pkg::ST_DZ |-> res_re == '0 && res_im == '0)
    else $error("Divide by zero with a nonzero result.");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == cau_pkg::ST_SAT |->
      res_re == MAXV || res_re == MINV || res_im == MAXV || res_im == MINV)
    else $error("Saturated status without a limit value.");
endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .res_re   (out_ch.res_re),
  .res_im   (out_ch.res_im),
  .status   (out_ch.status)
);
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the complex arithmetic unit with a bit-exact predictor.
`timescale 1ns / 1ps
module testbench;
  localparam int LATENCY   = cau_pkg::DATA_WIDTH + 4;
  localparam int N_RANDOM  = 1150;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] a_re;
    logic [15:0] a_im;
    logic [15:0] b_re;
    logic [15:0] b_im;
  } operands_t;

  typedef struct packed {
    logic [15:0] res_re;
    logic [15:0] res_im;
    logic [1:0]  status;
  } result_t;

  typedef struct {
    operands_t op;
    bit        fixed;
    result_t   res;
  } vector_t;

  logic clk;
  logic rst_n;
  cau_in_if  in_ch();
  cau_out_if out_ch();

  complex_arithmetic_unit u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  result_t   pending_results[$];
  vector_t   vectors[$];
  int        mismatches;
  int        results_seen;
  int        ops_count[4];
  int        cycle_count;
  bit        hold_off;
  bit        stimulus_done;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] clamp_part(logic signed [127:0] v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // Quotient rounded to nearest with ties away from zero.
  function automatic logic signed [127:0] round_div(logic signed [127:0] num,
                                                    logic [127:0] den);
    logic [127:0] m, q, r;
    m = (num < 0) ? -num : num;
    q = m / den;
    r = m % den;
    if (r >= den - r) q = q + 1;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic result_t compute_result(operands_t op);
    longint a, b, c, d;
    logic signed [127:0] re, im, den;
    result_t res;
    bit sat;
    a = $signed(op.a_re);
    b = $signed(op.a_im);
    c = $signed(op.b_re);
    d = $signed(op.b_im);
    sat = 1'b0;
    case (op.func)
      cau_pkg::FN_ADD: begin
        re = a + c;
        im = b + d;
      end
      cau_pkg::FN_SUB: begin
        re = a - c;
        im = b - d;
      end
      cau_pkg::FN_MUL: begin
        re = round_div(a * c - b * d, 128'd4096);
        im = round_div(a * d + b * c, 128'd4096);
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          res.res_re = '0;
          res.res_im = '0;
          res.status = cau_pkg::ST_DZ;
          return res;
        end
        re = round_div((a * c + b * d) * 4096, den);
        im = round_div((b * c - a * d) * 4096, den);
      end
    endcase
    res.res_re = clamp_part(re, sat);
    res.res_im = clamp_part(im, sat);
    res.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    return res;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 8191)) - 4096);
      4: return 16'(int'($urandom_range(0, 255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_row(logic [1:0] f, logic [15:0] ar, logic [15:0] ai,
                                  logic [15:0] br, logic [15:0] bi, bit fixed = 0,
                                  logic [15:0] rr = 0, logic [15:0] ri = 0,
                                  logic [1:0] st = 0);
    vector_t v;
    v.op = '{f, ar, ai, br, bi};
    v.fixed = fixed;
    v.res = '{rr, ri, st};
    vectors.push_back(v);
  endfunction

  task automatic send_op(operands_t op);
    in_ch.valid <= 1'b1;
    in_ch.func  <= op.func;
    in_ch.a_re  <= op.a_re;
    in_ch.a_im  <= op.a_im;
    in_ch.b_re  <= op.b_re;
    in_ch.b_im  <= op.b_im;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ops_count[op.func]++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    operands_t op;
    mismatches = 0;
    results_seen = 0;
    hold_off = 1'b0;
    stimulus_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = cau_pkg::FN_ADD;
    in_ch.a_re = '0;
    in_ch.a_im = '0;
    in_ch.b_re = '0;
    in_ch.b_im = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(cau_pkg::FN_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            1, 16'h0000, 16'h0000, cau_pkg::ST_OK);
    add_row(cau_pkg::FN_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
            1, 16'h7fff, 16'h8000, cau_pkg::ST_SAT);
    add_row(cau_pkg::FN_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
            1, 16'h8000, 16'h7fff, cau_pkg::ST_SAT);
    add_row(cau_pkg::FN_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff,
            1, 16'h8000, 16'h7fff, cau_pkg::ST_SAT);
    add_row(cau_pkg::FN_SUB, 16'h1234, 16'h5678, 16'h1234, 16'h5678,
            1, 16'h0000, 16'h0000, cau_pkg::ST_OK);
    add_row(cau_pkg::FN_MUL, 16'h1000, 16'h0000, 16'h1000, 16'h0000,
            1, 16'h1000, 16'h0000, cau_pkg::ST_OK);
    add_row(cau_pkg::FN_MUL, 16'h0000, 16'h1000, 16'h0000, 16'h1000,
            1, 16'hf000, 16'h0000, cau_pkg::ST_OK);
    add_row(cau_pkg::FN_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_row(cau_pkg::FN_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    add_row(cau_pkg::FN_MUL, 16'h0001, 16'h0000, 16'h0800, 16'h0000);
    add_row(cau_pkg::FN_MUL, 16'hffff, 16'h0000, 16'h0800, 16'h0000);
    add_row(cau_pkg::FN_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000,
            1, 16'h0000, 16'h0000, cau_pkg::ST_DZ);
    add_row(cau_pkg::FN_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            1, 16'h0000, 16'h0000, cau_pkg::ST_DZ);
    add_row(cau_pkg::FN_DIV, 16'h1000, 16'h0000, 16'h1000, 16'h0000,
            1, 16'h1000, 16'h0000, cau_pkg::ST_OK);
    add_row(cau_pkg::FN_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000,
            1, 16'h7fff, 16'h7fff, cau_pkg::ST_SAT);
    add_row(cau_pkg::FN_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001);
    add_row(cau_pkg::FN_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff);
    add_row(cau_pkg::FN_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    add_row(cau_pkg::FN_DIV, 16'h0001, 16'h0000, 16'h2000, 16'h0000);
    add_row(cau_pkg::FN_DIV, 16'hffff, 16'h0000, 16'h2000, 16'h0000);

    foreach (vectors[i]) begin
      pending_results.push_back(vectors[i].fixed ? vectors[i].res
                                                 : compute_result(vectors[i].op));
      send_op(vectors[i].op);
      idle_gap();
    end
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 700) drain_results();
      op.func = 2'($urandom);
      op.a_re = pick_value();
      op.a_im = pick_value();
      op.b_re = pick_value();
      op.b_im = pick_value();
      if (op.func == cau_pkg::FN_DIV && $urandom_range(0, 19) == 0) begin
        op.b_re = '0;
        op.b_im = '0;
      end
      pending_results.push_back(compute_result(op));
      send_op(op);
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
    in_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 3) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    wait (hold_off);
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.res_re, out_ch.res_im, out_ch.status};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %p.", got);
      end else begin
        want = pending_results.pop_front();
        if (got.res_re !== want.res_re || got.res_im !== want.res_im
            || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at result %0d: expected %p, got %p.", results_seen, want, got);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (stimulus_done && pending_results.size() == 0) begin
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d results: %0d add, %0d subtract, %0d multiply, %0d divide.",
                 results_seen, ops_count[0], ops_count[1], ops_count[2], ops_count[3]);
        if (mismatches == 0 && pending_results.size() == 0) begin
          $display("testbench passed");
        end else begin
          $display("%0d mismatches, %0d results missing.", mismatches,
                   pending_results.size());
          $display("testbench failed");
        end
        $finish;
      end else if (cycle_count >= MAX_CYCLE) begin
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("testbench failed");
        $finish;
      end
    end
  end
endmodule
